[design/ttip_pkg.sv]
// Shared types and constants for the text-to-integer parser.
// Used by every module of the block; depends on nothing.
package ttip_pkg;

  // Configuration register indexes and data width
  localparam int unsigned CfgDataW = 6;
  localparam int unsigned CfgIdxW  = 1;
  localparam logic [CfgIdxW-1:0] CFG_NUMBER_BASE = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_SIGNED_MODE = 1'b1;

  // Register reset values
  localparam logic [CfgDataW-1:0] BASE_RESET   = 6'd10;
  localparam logic                SIGNED_RESET = 1'b1;

  // Bases the prefix logic deals with
  localparam logic [5:0] BASE_DETECT = 6'd0;
  localparam logic [5:0] BASE_OCT    = 6'd8;
  localparam logic [5:0] BASE_DEC    = 6'd10;
  localparam logic [5:0] BASE_HEX    = 6'd16;

  // Characters of interest
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_LZ    = 8'h7A;
  localparam logic [5:0] ALPHA_OFFSET = 6'd10;

  // Queue between front and back
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = 1;
  localparam int unsigned QueueCntW  = 2;

  typedef struct packed {
    logic       start_req;
    logic [7:0] ch;
  } in_item_t;

  typedef struct packed {
    logic [63:0] value;
    logic [15:0] end_index;
  } out_item_t;

  // One character after classification
  typedef struct packed {
    logic       start;
    logic       nul;
    logic       space;
    logic       minus;
    logic       plus;
    logic       zero;
    logic       ex;
    logic       alnum;
    logic [5:0] digit;
  } ch_class_t;

  typedef enum logic [2:0] {
    PH_DONE,
    PH_SPACE,
    PH_AFTER_SIGN,
    PH_ZERO,
    PH_DIGITS
  } phase_e;

endpackage

[design/ttip_front.sv]
// Front end: decodes one incoming character into class flags and digit value.
// Depends on ttip_pkg.
module ttip_front (
  input  ttip_pkg::in_item_t  item_i,
  output ttip_pkg::ch_class_t cls_o
);

  logic [7:0] c;
  assign c = item_i.ch;

  // Character classes and digit value
  always_comb begin
    cls_o       = '0;
    cls_o.start = item_i.start_req;
    cls_o.nul   = (c == ttip_pkg::CH_NUL);
    cls_o.space = (c == ttip_pkg::CH_SPACE) || (c == ttip_pkg::CH_TAB) ||
                  (c == ttip_pkg::CH_LF) || (c == ttip_pkg::CH_CR);
    cls_o.minus = (c == ttip_pkg::CH_MINUS);
    cls_o.plus  = (c == ttip_pkg::CH_PLUS);
    cls_o.zero  = (c == ttip_pkg::CH_0);
    cls_o.ex    = (c == ttip_pkg::CH_LX) || (c == ttip_pkg::CH_UX);
    priority if (c >= ttip_pkg::CH_0 && c <= ttip_pkg::CH_9) begin
      cls_o.alnum = 1'b1;
      cls_o.digit = 6'(c - ttip_pkg::CH_0);
    end else if (c >= ttip_pkg::CH_LA && c <= ttip_pkg::CH_LZ) begin
      cls_o.alnum = 1'b1;
      cls_o.digit = 6'(c - ttip_pkg::CH_LA) + ttip_pkg::ALPHA_OFFSET;
    end else if (c >= ttip_pkg::CH_UA && c <= ttip_pkg::CH_UZ) begin
      cls_o.alnum = 1'b1;
      cls_o.digit = 6'(c - ttip_pkg::CH_UA) + ttip_pkg::ALPHA_OFFSET;
    end else begin
      cls_o.alnum = 1'b0;
      cls_o.digit = '0;
    end
  end

endmodule

[design/ttip_queue.sv]
// Two-entry queue of classified characters between front and back.
// Depends on ttip_pkg.
module ttip_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  ttip_pkg::ch_class_t push_data_i,
  output logic                full_o,
  output logic                pop_valid_o,
  input  logic                pop_ready_i,
  output ttip_pkg::ch_class_t pop_data_o
);

  ttip_pkg::ch_class_t mem_q [ttip_pkg::QueueDepth];
  logic [ttip_pkg::QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [ttip_pkg::QueueCntW-1:0] count_q, count_d;
  logic do_push, do_pop;

  assign full_o      = (count_q == ttip_pkg::QueueCntW'(ttip_pkg::QueueDepth));
  assign pop_valid_o = (count_q != '0);
  assign do_push     = push_i && !full_o;
  assign do_pop      = pop_valid_o && pop_ready_i;
  assign pop_data_o  = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (do_push && !do_pop) count_d = count_q + 1'b1;
    else if (!do_push && do_pop) count_d = count_q - 1'b1;
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_data_i;
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      count_q <= count_d;
    end
  end

endmodule

[design/ttip_back.sv]
// Back end: parse state machine, multiply-accumulate and result register.
// Depends on ttip_pkg.
module ttip_back #(
  parameter longint unsigned INDEX_LIMIT = 65535
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [5:0]          number_base_i,
  input  logic                signed_mode_i,
  input  logic                pop_valid_i,
  output logic                pop_ready_o,
  input  ttip_pkg::ch_class_t cls_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ttip_pkg::out_item_t out_item_o
);

  localparam int unsigned IdxW = $clog2(INDEX_LIMIT + 1);
  localparam logic [IdxW-1:0] IdxMax = IdxW'(INDEX_LIMIT);

  ttip_pkg::phase_e phase_q, phase_d, ph;
  logic [63:0]     acc_q, acc_d, acc;
  logic            minus_q, minus_d, mn;
  logic [5:0]      wb_q, wb_d, wb;
  logic [IdxW-1:0] idx_q, idx_d, idx;
  logic            out_valid_q;
  ttip_pkg::out_item_t out_item_q;
  logic step, bump, do_after, run_digit, take_digit, emit;
  logic [63:0] mac;

  assign pop_ready_o = !out_valid_q || out_ready_i;
  assign step        = pop_valid_i && pop_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // One character of the parse
  always_comb begin
    ph  = cls_i.start ? ttip_pkg::PH_SPACE : phase_q;
    acc = cls_i.start ? '0 : acc_q;
    mn  = cls_i.start ? 1'b0 : minus_q;
    wb  = cls_i.start ? number_base_i : wb_q;
    idx = cls_i.start ? '0 : idx_q;
    phase_d    = ph;
    bump       = 1'b0;
    do_after   = 1'b0;
    run_digit  = 1'b0;
    take_digit = 1'b0;
    emit       = 1'b0;
    unique case (ph)
      ttip_pkg::PH_SPACE: begin
        if (cls_i.space) begin
          bump = 1'b1;
        end else if (cls_i.minus || cls_i.plus) begin
          mn      = mn | cls_i.minus;
          bump    = 1'b1;
          phase_d = ttip_pkg::PH_AFTER_SIGN;
        end else begin
          do_after = 1'b1;
        end
      end
      ttip_pkg::PH_AFTER_SIGN: do_after = 1'b1;
      ttip_pkg::PH_ZERO: begin
        phase_d = ttip_pkg::PH_DIGITS;
        if (cls_i.ex) begin
          if (wb == ttip_pkg::BASE_DETECT) wb = ttip_pkg::BASE_HEX;
          bump = 1'b1;
        end else begin
          if (wb == ttip_pkg::BASE_DETECT) wb = ttip_pkg::BASE_OCT;
          run_digit = 1'b1;
        end
      end
      ttip_pkg::PH_DIGITS: run_digit = 1'b1;
      default: ;
    endcase
    // Optional radix prefix after whitespace and sign
    if (do_after) begin
      if ((wb == ttip_pkg::BASE_DETECT || wb == ttip_pkg::BASE_HEX) && cls_i.zero) begin
        bump    = 1'b1;
        phase_d = ttip_pkg::PH_ZERO;
      end else begin
        if (wb == ttip_pkg::BASE_DETECT) wb = ttip_pkg::BASE_DEC;
        phase_d   = ttip_pkg::PH_DIGITS;
        run_digit = 1'b1;
      end
    end
    // Digit accept or end of number
    if (run_digit) begin
      if (cls_i.nul || !cls_i.alnum || cls_i.digit >= wb) begin
        emit    = 1'b1;
        phase_d = ttip_pkg::PH_DONE;
      end else begin
        take_digit = 1'b1;
        bump       = 1'b1;
      end
    end
    mac     = acc * 64'(wb) + 64'(cls_i.digit);
    acc_d   = take_digit ? mac : acc;
    minus_d = mn;
    wb_d    = wb;
    idx_d   = (bump && idx < IdxMax) ? idx + 1'b1 : idx;
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (step && emit) begin
      out_item_q.value     <= (signed_mode_i && mn) ? 64'd0 - acc : acc;
      out_item_q.end_index <= 16'(idx);
    end
  end

  // Parse state and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= ttip_pkg::PH_DONE;
      acc_q       <= '0;
      minus_q     <= 1'b0;
      wb_q        <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (step) begin
        phase_q <= phase_d;
        acc_q   <= acc_d;
        minus_q <= minus_d;
        wb_q    <= wb_d;
        idx_q   <= idx_d;
      end
      if (step && emit) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

endmodule

[design/text_to_integer_parser.sv]
// Top level of the text-to-integer parser: configuration registers and wiring.
// Depends on ttip_pkg, ttip_front, ttip_queue and ttip_back.
//
// Parses a string fed one character per transfer into a 64-bit integer the
// way strtol/strtoul do: leading whitespace, optional sign, optional 0x or 0
// prefix, then digits accumulated modulo 2^64. One character is taken every
// clock cycle while the queue is not full; the back end does one 64-by-6-bit
// multiply-add per character. A result (value and end index) is loaded into
// the output register at the edge where the terminating character, held in
// the two-entry queue since its input transfer, leaves it. The input stalls
// only when the result register is held and the queue is full. number_base
// is latched at each start character and signed_mode is sampled when the
// result is formed; write them only while the block is idle.
module text_to_integer_parser #(
  parameter longint unsigned INDEX_LIMIT = 65535
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [ttip_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [ttip_pkg::CfgDataW-1:0]       cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  ttip_pkg::in_item_t                  in_item_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output ttip_pkg::out_item_t                 out_item_o
);

  logic [5:0] number_base_q;
  logic       signed_mode_q;
  ttip_pkg::ch_class_t cls_in, cls_out;
  logic full, pop_valid, pop_ready;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      number_base_q <= ttip_pkg::BASE_RESET;
      signed_mode_q <= ttip_pkg::SIGNED_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ttip_pkg::CFG_NUMBER_BASE: number_base_q <= cfg_data_i;
        ttip_pkg::CFG_SIGNED_MODE: signed_mode_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign in_ready_o = !full;

  ttip_front u_front (
    .item_i (in_item_i),
    .cls_o  (cls_in)
  );

  ttip_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_valid_i),
    .push_data_i (cls_in),
    .full_o      (full),
    .pop_valid_o (pop_valid),
    .pop_ready_i (pop_ready),
    .pop_data_o  (cls_out)
  );

  ttip_back #(
    .INDEX_LIMIT (INDEX_LIMIT)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .number_base_i (number_base_q),
    .signed_mode_i (signed_mode_q),
    .pop_valid_i   (pop_valid),
    .pop_ready_o   (pop_ready),
    .cls_i         (cls_out),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_item_o    (out_item_o)
  );

endmodule
